@@ hw/rtl/i2cbm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master package
// Shared types, codes and constants for the bit-level I2C master.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

  // Register map
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_TICKS_PER_US = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_ACK_TIMEOUT  = 1'd1;

  localparam logic [9:0] TICKS_PER_US_RESET = 10'd80;
  localparam logic [9:0] ACK_TIMEOUT_RESET  = 10'd250;

  // Host command codes
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // Phase lengths as shifts of the per-microsecond tick count
  localparam logic [1:0] SH_1US = 2'd0;
  localparam logic [1:0] SH_2US = 2'd1;
  localparam logic [1:0] SH_4US = 2'd2;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_received;
    logic       timed_out;
  } out_item_t;

  typedef struct packed {
    logic [9:0] ticks_per_us;
    logic [9:0] ack_timeout;
  } cfg_t;

  // Classified operation carried by one tick
  typedef enum logic [2:0] {
    OP_TICK,
    OP_START,
    OP_STOP,
    OP_WRITE,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] wbyte;
    logic       send_ack;
    logic       sda;
  } tick_t;

  // Bus sequencer steps
  typedef enum logic [4:0] {
    ST_IDLE      = 5'd0,
    ST_START_A   = 5'd1,
    ST_START_B   = 5'd2,
    ST_START_C   = 5'd3,
    ST_STOP_A    = 5'd4,
    ST_STOP_B    = 5'd5,
    ST_WR_BIT    = 5'd6,
    ST_WR_HIGH   = 5'd7,
    ST_WR_LOW    = 5'd8,
    ST_ACK_REL   = 5'd9,
    ST_ACK_CLK   = 5'd10,
    ST_ACK_POLL  = 5'd11,
    ST_RD_LOW    = 5'd12,
    ST_RD_SAMPLE = 5'd13,
    ST_RA_SET    = 5'd14,
    ST_RA_HIGH   = 5'd15,
    ST_RA_LOW    = 5'd16,
    ST_ACK_LOW   = 5'd17,
    ST_FINISH    = 5'd31
  } step_e;

endpackage

@@ hw/rtl/i2cbm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master front end
// Accepts tick transactions and classifies the command field into an op.
// ----------------------------------------------------------------------------
module i2cbm_front (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  i2cbm_pkg::in_item_t in_item_i,
  input  logic               q_full_i,
  output logic               push_o,
  output i2cbm_pkg::tick_t   entry_o
);

  i2cbm_pkg::op_e op;

  // Command decode; unknown codes act as a plain tick
  always_comb begin
    unique case (in_item_i.command)
      i2cbm_pkg::CMD_START: op = i2cbm_pkg::OP_START;
      i2cbm_pkg::CMD_STOP:  op = i2cbm_pkg::OP_STOP;
      i2cbm_pkg::CMD_WRITE: op = i2cbm_pkg::OP_WRITE;
      i2cbm_pkg::CMD_READ:  op = i2cbm_pkg::OP_READ;
      default:              op = i2cbm_pkg::OP_TICK;
    endcase
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  assign entry_o.op       = op;
  assign entry_o.wbyte    = in_item_i.write_byte;
  assign entry_o.send_ack = in_item_i.send_ack;
  assign entry_o.sda      = in_item_i.sda_sample;

endmodule

@@ hw/rtl/i2cbm_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master tick queue
// Small FIFO of classified ticks between the front end and the sequencer.
// ----------------------------------------------------------------------------
module i2cbm_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  i2cbm_pkg::tick_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output i2cbm_pkg::tick_t entry_o
);

  localparam int unsigned PtrW = (i2cbm_pkg::QueueDepth > 1) ?
                                 $clog2(i2cbm_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(i2cbm_pkg::QueueDepth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(i2cbm_pkg::QueueDepth);
  localparam logic [PtrW-1:0] LastP  = PtrW'(i2cbm_pkg::QueueDepth - 1);

  i2cbm_pkg::tick_t mem_q [i2cbm_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == DepthC);
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastP) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastP) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

@@ hw/rtl/i2cbm_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bus sequencer
// Runs one tick per cycle, unless the output stalls, through the start, stop,
// write and read phases and registers bus levels and status as one result.
// ----------------------------------------------------------------------------
module i2cbm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  i2cbm_pkg::cfg_t      cfg_i,
  input  logic                 q_valid_i,
  input  i2cbm_pkg::tick_t     q_item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output i2cbm_pkg::out_item_t out_item_o
);

  i2cbm_pkg::step_e step_q, step_d, tgt, nx;
  logic [11:0] delay_q, delay_d;
  logic [3:0]  bit_q, bit_d, bit_b;
  logic [7:0]  shift_q, shift_d, shift_b;
  logic [9:0]  wait_q, wait_d, wait_b;
  logic [1:0]  stat_q, stat_d, stat_b;
  logic        scl_q, scl_d, sda_q, sda_d;
  logic        choice_q, choice_d;
  logic [7:0]  rdbyte_q, rdbyte_d;
  logic        enter, done, tmo, pop;
  logic        out_valid_q;
  i2cbm_pkg::out_item_t out_item_q, out_item_d;

  // Phase length: (us * ticks_per_us) - 1, zero stays zero
  function automatic logic [11:0] load_us(input logic [1:0] sh, input logic [9:0] tpu);
    logic [11:0] d;
    d = {2'b00, tpu} << sh;
    return (d == '0) ? '0 : d - 12'd1;
  endfunction

  // Step that follows a finished phase
  function automatic i2cbm_pkg::step_e next_step(input i2cbm_pkg::step_e s,
                                                 input logic [3:0] b);
    i2cbm_pkg::step_e r;
    unique case (s)
      i2cbm_pkg::ST_START_A:   r = i2cbm_pkg::ST_START_B;
      i2cbm_pkg::ST_START_B:   r = i2cbm_pkg::ST_START_C;
      i2cbm_pkg::ST_STOP_A:    r = i2cbm_pkg::ST_STOP_B;
      i2cbm_pkg::ST_WR_BIT:    r = i2cbm_pkg::ST_WR_HIGH;
      i2cbm_pkg::ST_WR_HIGH:   r = i2cbm_pkg::ST_WR_LOW;
      i2cbm_pkg::ST_WR_LOW:    r = (b < i2cbm_pkg::BITS_PER_BYTE) ?
                                   i2cbm_pkg::ST_WR_BIT : i2cbm_pkg::ST_ACK_REL;
      i2cbm_pkg::ST_ACK_REL:   r = i2cbm_pkg::ST_ACK_CLK;
      i2cbm_pkg::ST_ACK_CLK:   r = i2cbm_pkg::ST_ACK_POLL;
      i2cbm_pkg::ST_RD_LOW:    r = i2cbm_pkg::ST_RD_SAMPLE;
      i2cbm_pkg::ST_RD_SAMPLE: r = (b < i2cbm_pkg::BITS_PER_BYTE) ?
                                   i2cbm_pkg::ST_RD_LOW : i2cbm_pkg::ST_RA_SET;
      i2cbm_pkg::ST_RA_SET:    r = i2cbm_pkg::ST_RA_HIGH;
      i2cbm_pkg::ST_RA_HIGH:   r = i2cbm_pkg::ST_RA_LOW;
      default:                 r = i2cbm_pkg::ST_FINISH;
    endcase
    return r;
  endfunction

  // A tick is taken when the result register is free or being drained
  assign pop   = q_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = pop;
  assign nx    = next_step(step_q, bit_q);

  // Next state
  always_comb begin
    enter  = 1'b0;
    tgt    = i2cbm_pkg::ST_IDLE;
    done   = 1'b0;
    tmo    = 1'b0;
    step_d = step_q;
    if (pop) begin
      unique case (step_q)
        i2cbm_pkg::ST_IDLE: begin
          unique case (q_item_i.op)
            i2cbm_pkg::OP_START: begin
              enter = 1'b1;
              tgt   = i2cbm_pkg::ST_START_A;
            end
            i2cbm_pkg::OP_STOP: begin
              enter = 1'b1;
              tgt   = i2cbm_pkg::ST_STOP_A;
            end
            i2cbm_pkg::OP_WRITE: begin
              enter = 1'b1;
              tgt   = i2cbm_pkg::ST_WR_BIT;
            end
            i2cbm_pkg::OP_READ: begin
              enter = 1'b1;
              tgt   = i2cbm_pkg::ST_RD_LOW;
            end
            default: ;
          endcase
        end
        i2cbm_pkg::ST_ACK_POLL: begin
          enter = 1'b1;
          tgt   = i2cbm_pkg::ST_ACK_POLL;
        end
        default: begin
          if (delay_q == '0) begin
            if (nx == i2cbm_pkg::ST_FINISH) begin
              step_d = i2cbm_pkg::ST_IDLE;
              done   = 1'b1;
            end else begin
              enter = 1'b1;
              tgt   = nx;
            end
          end
        end
      endcase
      if (enter) begin
        step_d = tgt;
        // The ACK poll checks SDA and the timeout on every tick it is entered
        if (tgt == i2cbm_pkg::ST_ACK_POLL) begin
          if (!q_item_i.sda) begin
            step_d = i2cbm_pkg::ST_ACK_LOW;
          end else if (wait_q >= cfg_i.ack_timeout) begin
            step_d = i2cbm_pkg::ST_STOP_A;
            tmo    = 1'b1;
          end
        end
      end
    end
  end

  // Datapath and bus levels
  always_comb begin
    delay_d  = delay_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    choice_d = choice_q;
    rdbyte_d = rdbyte_q;
    shift_b  = shift_q;
    bit_b    = bit_q;
    wait_b   = wait_q;
    stat_b   = stat_q;
    // Command setup from idle
    if (pop && enter && step_q == i2cbm_pkg::ST_IDLE) begin
      if (q_item_i.op == i2cbm_pkg::OP_WRITE) begin
        shift_b = q_item_i.wbyte;
        bit_b   = '0;
        wait_b  = '0;
        stat_b  = '0;
      end else if (q_item_i.op == i2cbm_pkg::OP_READ) begin
        shift_b  = '0;
        bit_b    = '0;
        choice_d = q_item_i.send_ack;
      end
    end
    shift_d = shift_b;
    bit_d   = bit_b;
    wait_d  = wait_b;
    stat_d  = stat_b;
    if (pop && !enter && step_q != i2cbm_pkg::ST_IDLE && delay_q != '0) begin
      delay_d = delay_q - 12'd1;
    end
    if (pop && enter) begin
      unique case (step_d)
        i2cbm_pkg::ST_START_A: begin
          sda_d   = 1'b1;
          scl_d   = 1'b1;
          delay_d = load_us(i2cbm_pkg::SH_4US, cfg_i.ticks_per_us);
        end
        i2cbm_pkg::ST_START_B: begin
          sda_d   = 1'b0;
          delay_d = load_us(i2cbm_pkg::SH_4US, cfg_i.ticks_per_us);
        end
        i2cbm_pkg::ST_START_C: begin
          scl_d   = 1'b0;
          delay_d = load_us(i2cbm_pkg::SH_4US, cfg_i.ticks_per_us);
        end
        i2cbm_pkg::ST_STOP_A: begin
          sda_d   = 1'b0;
          scl_d   = 1'b1;
          delay_d = load_us(i2cbm_pkg::SH_4US, cfg_i.ticks_per_us);
          if (tmo) begin
            stat_d = 2'b10;
          end
        end
        i2cbm_pkg::ST_STOP_B: begin
          sda_d   = 1'b1;
          scl_d   = 1'b1;
          delay_d = load_us(i2cbm_pkg::SH_4US, cfg_i.ticks_per_us);
        end
        i2cbm_pkg::ST_WR_BIT: begin
          scl_d   = 1'b0;
          sda_d   = shift_b[7];
          shift_d = {shift_b[6:0], 1'b0};
          delay_d = load_us(i2cbm_pkg::SH_2US, cfg_i.ticks_per_us);
        end
        i2cbm_pkg::ST_WR_HIGH: begin
          scl_d   = 1'b1;
          delay_d = load_us(i2cbm_pkg::SH_2US, cfg_i.ticks_per_us);
        end
        i2cbm_pkg::ST_WR_LOW: begin
          scl_d   = 1'b0;
          bit_d   = bit_b + 4'd1;
          delay_d = load_us(i2cbm_pkg::SH_2US, cfg_i.ticks_per_us);
        end
        i2cbm_pkg::ST_ACK_REL: begin
          sda_d   = 1'b1;
          delay_d = load_us(i2cbm_pkg::SH_1US, cfg_i.ticks_per_us);
        end
        i2cbm_pkg::ST_ACK_CLK: begin
          scl_d   = 1'b1;
          delay_d = load_us(i2cbm_pkg::SH_1US, cfg_i.ticks_per_us);
        end
        i2cbm_pkg::ST_ACK_POLL: begin
          // SDA still high, keep counting
          delay_d = '0;
          wait_d  = wait_b + 10'd1;
        end
        i2cbm_pkg::ST_ACK_LOW: begin
          stat_d  = stat_b | 2'b01;
          scl_d   = 1'b0;
          delay_d = '0;
        end
        i2cbm_pkg::ST_RD_LOW: begin
          scl_d   = 1'b0;
          sda_d   = 1'b1;
          delay_d = load_us(i2cbm_pkg::SH_2US, cfg_i.ticks_per_us);
        end
        i2cbm_pkg::ST_RD_SAMPLE: begin
          scl_d   = 1'b1;
          shift_d = {shift_b[6:0], q_item_i.sda};
          bit_d   = bit_b + 4'd1;
          delay_d = '0;
          if (bit_d >= i2cbm_pkg::BITS_PER_BYTE) begin
            rdbyte_d = shift_d;
          end
        end
        i2cbm_pkg::ST_RA_SET: begin
          scl_d   = 1'b0;
          sda_d   = !choice_q;
          delay_d = load_us(i2cbm_pkg::SH_2US, cfg_i.ticks_per_us);
        end
        i2cbm_pkg::ST_RA_HIGH: begin
          scl_d   = 1'b1;
          delay_d = load_us(i2cbm_pkg::SH_2US, cfg_i.ticks_per_us);
        end
        i2cbm_pkg::ST_RA_LOW: begin
          scl_d   = 1'b0;
          delay_d = '0;
        end
        default: begin
          delay_d = '0;
        end
      endcase
    end
  end

  // Result for this tick
  always_comb begin
    out_item_d.scl_level    = scl_d;
    out_item_d.sda_release  = sda_d;
    out_item_d.busy_res     = (step_d != i2cbm_pkg::ST_IDLE);
    out_item_d.done_res     = done;
    out_item_d.read_byte    = rdbyte_d;
    out_item_d.ack_received = stat_d[0];
    out_item_d.timed_out    = stat_d[1];
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= i2cbm_pkg::ST_IDLE;
      delay_q  <= '0;
      bit_q    <= '0;
      shift_q  <= '0;
      wait_q   <= '0;
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
      stat_q   <= '0;
      choice_q <= 1'b0;
      rdbyte_q <= '0;
    end else if (pop) begin
      step_q   <= step_d;
      delay_q  <= delay_d;
      bit_q    <= bit_d;
      shift_q  <= shift_d;
      wait_q   <= wait_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
      stat_q   <= stat_d;
      choice_q <= choice_d;
      rdbyte_q <= rdbyte_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ hw/rtl/i2c_bit_level_master.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master
// Each tick transaction advances the bus sequencer by one time step and
// returns one result with the SCL/SDA levels and status.
// ----------------------------------------------------------------------------
// Usage: every input transaction is one bus time tick and yields exactly one
// result transaction. The block sustains one tick per clock cycle while the
// output is not stalled; each accepted tick is written into the two-entry
// tick queue and then registered as the sequencer's result. The sequencer
// advances its phase counter once per tick. Phase lengths are 1, 2 or 4
// microseconds of ticks_per_us ticks each; commands are only honored on ticks
// that arrive while the bus sequencer is idle.
// Configuration writes are always accepted and take effect immediately.
module i2c_bit_level_master (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  i2cbm_pkg::in_item_t                  in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output i2cbm_pkg::out_item_t                 out_item_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [i2cbm_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [9:0]                           cfg_data_i
);

  i2cbm_pkg::cfg_t  cfg_q;
  i2cbm_pkg::tick_t push_entry, q_entry;
  logic             push, q_full, q_valid, pop;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_us <= i2cbm_pkg::TICKS_PER_US_RESET;
      cfg_q.ack_timeout  <= i2cbm_pkg::ACK_TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        i2cbm_pkg::REG_TICKS_PER_US: cfg_q.ticks_per_us <= cfg_data_i;
        i2cbm_pkg::REG_ACK_TIMEOUT:  cfg_q.ack_timeout  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  i2cbm_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  i2cbm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  i2cbm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ sim/i2c_bit_level_master_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-level master testbench
// Streams bus time ticks into the master and checks every tick result against
// a cycle-free model of the SCL/SDA sequencer. Covers start, stop, write with
// slave ACK and ACK timeout, read with ACK/NACK, ignored commands, zero phase
// timing, the widest ACK wait limit, and output back-pressure.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_tb;

  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Tick-only code and first reserved code (treated as tick only)
  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;

  // Write status bits
  localparam logic [1:0] FLAG_ACK     = 2'b01;
  localparam logic [1:0] FLAG_TIMEOUT = 2'b10;

  // Level presented on SDA outside the ACK poll
  localparam logic [1:0] LINE_RANDOM = 2'd0;
  localparam logic [1:0] LINE_HIGH   = 2'd1;
  localparam logic [1:0] LINE_LOW    = 2'd2;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid;
  logic                          in_ready;
  i2cbm_pkg::in_item_t           in_item;
  logic                          out_valid;
  logic                          out_ready;
  i2cbm_pkg::out_item_t          out_item;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [i2cbm_pkg::CfgIdxW-1:0] cfg_index;
  logic [9:0]                    cfg_data;

  i2c_bit_level_master u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Sequencer model state
  i2cbm_pkg::step_e seq_step;
  logic [11:0]      phase_delay;
  logic [3:0]       bit_cnt;
  logic [7:0]       shift_q;
  logic [9:0]       poll_count;
  logic             scl_q;
  logic             sda_q;
  logic [1:0]       status_q;
  logic             ack_sel;
  logic [7:0]       read_q;
  logic [9:0]       tpu_cfg;
  logic [9:0]       ack_limit_cfg;

  i2cbm_pkg::out_item_t tick_results[$];
  i2cbm_pkg::out_item_t want;

  // Stimulus controls
  bit          src_gaps = 1'b1;
  bit          sink_gaps = 1'b1;
  bit          busy_noise = 1'b1;
  int unsigned ack_odds = 1;
  logic [1:0]  line_mode = LINE_RANDOM;
  int unsigned hold_request = 0;
  int unsigned hold_len;

  // Bookkeeping
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned ticks_sent = 0;
  int unsigned n_starts = 0;
  int unsigned n_stops = 0;
  int unsigned n_writes = 0;
  int unsigned n_reads = 0;
  int unsigned n_acked = 0;
  int unsigned n_timeouts = 0;

  // --------------------------------------------------------------------------
  // Sequencer model
  // --------------------------------------------------------------------------
  function automatic void reset_bus_model();
    seq_step      = i2cbm_pkg::ST_IDLE;
    phase_delay   = '0;
    bit_cnt       = '0;
    shift_q       = '0;
    poll_count    = '0;
    scl_q         = 1'b1;
    sda_q         = 1'b1;
    status_q      = '0;
    ack_sel       = 1'b0;
    read_q        = '0;
    tpu_cfg       = i2cbm_pkg::TICKS_PER_US_RESET;
    ack_limit_cfg = i2cbm_pkg::ACK_TIMEOUT_RESET;
  endfunction

  // Phase of 'us' microseconds: remaining ticks after the first one
  function automatic void load_delay(input int unsigned us);
    int unsigned d;
    d = us * tpu_cfg;
    phase_delay = (d == 0) ? 12'd0 : 12'(d - 1);
  endfunction

  function automatic i2cbm_pkg::step_e phase_after(input i2cbm_pkg::step_e s);
    case (s)
      i2cbm_pkg::ST_START_A: return i2cbm_pkg::ST_START_B;
      i2cbm_pkg::ST_START_B: return i2cbm_pkg::ST_START_C;
      i2cbm_pkg::ST_STOP_A:  return i2cbm_pkg::ST_STOP_B;
      i2cbm_pkg::ST_WR_BIT:  return i2cbm_pkg::ST_WR_HIGH;
      i2cbm_pkg::ST_WR_HIGH: return i2cbm_pkg::ST_WR_LOW;
      i2cbm_pkg::ST_WR_LOW: begin
        if (bit_cnt < i2cbm_pkg::BITS_PER_BYTE) return i2cbm_pkg::ST_WR_BIT;
        return i2cbm_pkg::ST_ACK_REL;
      end
      i2cbm_pkg::ST_ACK_REL: return i2cbm_pkg::ST_ACK_CLK;
      i2cbm_pkg::ST_ACK_CLK: return i2cbm_pkg::ST_ACK_POLL;
      i2cbm_pkg::ST_RD_LOW:  return i2cbm_pkg::ST_RD_SAMPLE;
      i2cbm_pkg::ST_RD_SAMPLE: begin
        if (bit_cnt < i2cbm_pkg::BITS_PER_BYTE) return i2cbm_pkg::ST_RD_LOW;
        return i2cbm_pkg::ST_RA_SET;
      end
      i2cbm_pkg::ST_RA_SET:  return i2cbm_pkg::ST_RA_HIGH;
      i2cbm_pkg::ST_RA_HIGH: return i2cbm_pkg::ST_RA_LOW;
      default:               return i2cbm_pkg::ST_FINISH;
    endcase
  endfunction

  // Apply the levels of a newly entered phase; an ACK poll may chain on
  function automatic void enter_phase(input i2cbm_pkg::step_e s, input logic sda);
    i2cbm_pkg::step_e nxt;
    logic             chain;
    nxt = s;
    do begin
      chain    = 1'b0;
      seq_step = nxt;
      case (nxt)
        i2cbm_pkg::ST_START_A: begin
          sda_q = 1'b1;
          scl_q = 1'b1;
          load_delay(4);
        end
        i2cbm_pkg::ST_START_B: begin
          sda_q = 1'b0;
          load_delay(4);
        end
        i2cbm_pkg::ST_START_C: begin
          scl_q = 1'b0;
          load_delay(4);
        end
        i2cbm_pkg::ST_STOP_A: begin
          sda_q = 1'b0;
          scl_q = 1'b1;
          load_delay(4);
        end
        i2cbm_pkg::ST_STOP_B: begin
          scl_q = 1'b1;
          sda_q = 1'b1;
          load_delay(4);
        end
        i2cbm_pkg::ST_WR_BIT: begin
          scl_q   = 1'b0;
          sda_q   = shift_q[7];
          shift_q = shift_q << 1;
          load_delay(2);
        end
        i2cbm_pkg::ST_WR_HIGH: begin
          scl_q = 1'b1;
          load_delay(2);
        end
        i2cbm_pkg::ST_WR_LOW: begin
          scl_q   = 1'b0;
          bit_cnt = bit_cnt + 1'b1;
          load_delay(2);
        end
        i2cbm_pkg::ST_ACK_REL: begin
          sda_q = 1'b1;
          load_delay(1);
        end
        i2cbm_pkg::ST_ACK_CLK: begin
          scl_q = 1'b1;
          load_delay(1);
        end
        i2cbm_pkg::ST_ACK_POLL: begin
          phase_delay = '0;
          if (!sda) begin
            status_q = status_q | FLAG_ACK;
            n_acked++;
            nxt   = i2cbm_pkg::ST_ACK_LOW;
            chain = 1'b1;
          end else if (poll_count >= ack_limit_cfg) begin
            status_q = FLAG_TIMEOUT;
            n_timeouts++;
            nxt   = i2cbm_pkg::ST_STOP_A;
            chain = 1'b1;
          end else begin
            poll_count = poll_count + 1'b1;
          end
        end
        i2cbm_pkg::ST_ACK_LOW: begin
          scl_q       = 1'b0;
          phase_delay = '0;
        end
        i2cbm_pkg::ST_RD_LOW: begin
          scl_q = 1'b0;
          sda_q = 1'b1;
          load_delay(2);
        end
        i2cbm_pkg::ST_RD_SAMPLE: begin
          scl_q   = 1'b1;
          shift_q = {shift_q[6:0], sda};
          bit_cnt = bit_cnt + 1'b1;
          if (bit_cnt >= i2cbm_pkg::BITS_PER_BYTE) read_q = shift_q;
          phase_delay = '0;
        end
        i2cbm_pkg::ST_RA_SET: begin
          scl_q = 1'b0;
          sda_q = ack_sel ? 1'b0 : 1'b1;
          load_delay(2);
        end
        i2cbm_pkg::ST_RA_HIGH: begin
          scl_q = 1'b1;
          load_delay(2);
        end
        i2cbm_pkg::ST_RA_LOW: begin
          scl_q       = 1'b0;
          phase_delay = '0;
        end
        default: begin
          seq_step    = i2cbm_pkg::ST_FINISH;
          phase_delay = '0;
        end
      endcase
    end while (chain);
  endfunction

  // One bus tick: update the model and return the levels the block reports
  function automatic i2cbm_pkg::out_item_t advance_bus_model(input i2cbm_pkg::in_item_t it);
    i2cbm_pkg::out_item_t r;
    logic                 done;
    i2cbm_pkg::step_e     nxt;
    done = 1'b0;
    if (seq_step == i2cbm_pkg::ST_IDLE) begin
      case (it.command)
        i2cbm_pkg::CMD_START: begin
          n_starts++;
          enter_phase(i2cbm_pkg::ST_START_A, it.sda_sample);
        end
        i2cbm_pkg::CMD_STOP: begin
          n_stops++;
          enter_phase(i2cbm_pkg::ST_STOP_A, it.sda_sample);
        end
        i2cbm_pkg::CMD_WRITE: begin
          n_writes++;
          shift_q    = it.write_byte;
          bit_cnt    = '0;
          poll_count = '0;
          status_q   = '0;
          enter_phase(i2cbm_pkg::ST_WR_BIT, it.sda_sample);
        end
        i2cbm_pkg::CMD_READ: begin
          n_reads++;
          shift_q = '0;
          bit_cnt = '0;
          ack_sel = it.send_ack;
          enter_phase(i2cbm_pkg::ST_RD_LOW, it.sda_sample);
        end
        default: ;
      endcase
    end else if (seq_step == i2cbm_pkg::ST_ACK_POLL) begin
      enter_phase(i2cbm_pkg::ST_ACK_POLL, it.sda_sample);
    end else if (phase_delay != 0) begin
      phase_delay = phase_delay - 1'b1;
    end else begin
      nxt = phase_after(seq_step);
      if (nxt == i2cbm_pkg::ST_FINISH) begin
        seq_step = i2cbm_pkg::ST_IDLE;
        done     = 1'b1;
      end else begin
        enter_phase(nxt, it.sda_sample);
      end
    end
    if (seq_step == i2cbm_pkg::ST_FINISH) begin
      seq_step = i2cbm_pkg::ST_IDLE;
      done     = 1'b1;
    end
    r.scl_level    = scl_q;
    r.sda_release  = sda_q;
    r.busy_res     = (seq_step != i2cbm_pkg::ST_IDLE);
    r.done_res     = done;
    r.read_byte    = read_q;
    r.ack_received = status_q[0];
    r.timed_out    = status_q[1];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Build a tick; SDA acts as the slave during the ACK poll
  function automatic i2cbm_pkg::in_item_t make_tick(input logic [2:0] cmd);
    i2cbm_pkg::in_item_t it;
    logic                poll_next;
    it.command    = cmd;
    it.write_byte = 8'($urandom);
    it.send_ack   = 1'($urandom);
    poll_next = (seq_step == i2cbm_pkg::ST_ACK_POLL) ||
                (seq_step == i2cbm_pkg::ST_ACK_CLK && phase_delay == 0);
    if (poll_next) begin
      it.sda_sample = (ack_odds != 0 && $urandom_range(ack_odds - 1) == 0) ? 1'b0 : 1'b1;
    end else begin
      case (line_mode)
        LINE_HIGH: it.sda_sample = 1'b1;
        LINE_LOW:  it.sda_sample = 1'b0;
        default:   it.sda_sample = 1'($urandom);
      endcase
    end
    return it;
  endfunction

  // Mostly well-formed traffic: commands when idle, rare noise while busy
  function automatic i2cbm_pkg::in_item_t random_tick();
    logic [2:0]  cmd;
    int unsigned r;
    cmd = CMD_TICK;
    if (seq_step == i2cbm_pkg::ST_IDLE) begin
      if ($urandom_range(99) < 80) begin
        r = $urandom_range(99);
        if (r < 20) begin
          cmd = i2cbm_pkg::CMD_START;
        end else if (r < 35) begin
          cmd = i2cbm_pkg::CMD_STOP;
        end else if (r < 65) begin
          cmd = i2cbm_pkg::CMD_WRITE;
          r   = $urandom_range(9);
          if (r < 2) ack_odds = 0;
          else if (r < 5) ack_odds = 1;
          else ack_odds = 2 + $urandom_range(3);
        end else if (r < 95) begin
          cmd = i2cbm_pkg::CMD_READ;
          if ($urandom_range(7) == 0) line_mode = $urandom_range(1) ? LINE_HIGH : LINE_LOW;
          else line_mode = LINE_RANDOM;
        end else begin
          cmd = 3'($urandom_range(7, CMD_RSVD_FIRST));
        end
      end
    end else if (busy_noise && $urandom_range(19) == 0) begin
      cmd = 3'($urandom_range(7));
    end
    return make_tick(cmd);
  endfunction

  // Offer one tick; the model advances on the accepting edge
  task automatic send_tick(input i2cbm_pkg::in_item_t it);
    if (src_gaps) begin
      while ($urandom_range(99) < 26) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (!in_ready);
    ticks_sent++;
    tick_results.push_back(advance_bus_model(it));
  endtask

  // Feed plain ticks until the sequencer is back to idle
  task automatic run_to_idle();
    while (seq_step != i2cbm_pkg::ST_IDLE) begin
      if (busy_noise && $urandom_range(9) == 0) send_tick(make_tick(3'($urandom_range(7))));
      else send_tick(make_tick(CMD_TICK));
    end
  endtask

  task automatic issue_cmd(input logic [2:0] cmd, input logic [7:0] wbyte, input logic sack);
    i2cbm_pkg::in_item_t it;
    it            = make_tick(cmd);
    it.write_byte = wbyte;
    it.send_ack   = sack;
    send_tick(it);
    run_to_idle();
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (tick_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [i2cbm_pkg::CfgIdxW-1:0] idx,
                           input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == i2cbm_pkg::REG_TICKS_PER_US) tpu_cfg = val;
    else if (idx == i2cbm_pkg::REG_ACK_TIMEOUT) ack_limit_cfg = val;
    @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [9:0] tpu, input logic [9:0] ack_limit);
    wait_results_drained();
    write_reg(i2cbm_pkg::REG_TICKS_PER_US, tpu);
    write_reg(i2cbm_pkg::REG_ACK_TIMEOUT, ack_limit);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Idle levels and a stop at the reset timing
  task automatic test_reset_defaults();
    repeat (3) send_tick(make_tick(CMD_TICK));
    issue_cmd(i2cbm_pkg::CMD_STOP, 8'h00, 1'b0);
  endtask

  // Zero ticks per microsecond: every phase is one tick
  task automatic test_directed_zero_tpu();
    set_timing(10'd0, 10'd0);
    send_tick(make_tick(CMD_TICK));
    issue_cmd(i2cbm_pkg::CMD_START, 8'h00, 1'b0);
    ack_odds = 1;
    issue_cmd(i2cbm_pkg::CMD_WRITE, 8'hFF, 1'b0);    // ACK on the first poll
    ack_odds = 0;
    issue_cmd(i2cbm_pkg::CMD_WRITE, 8'h00, 1'b1);    // no ACK, zero timeout
    set_timing(10'd0, 10'd3);
    ack_odds = 0;
    issue_cmd(i2cbm_pkg::CMD_WRITE, 8'h5A, 1'b1);    // times out after several polls
    ack_odds = 3;
    issue_cmd(i2cbm_pkg::CMD_WRITE, 8'hA5, 1'b0);
    line_mode = LINE_HIGH;
    issue_cmd(i2cbm_pkg::CMD_READ, 8'h00, 1'b1);     // all ones, ACK
    line_mode = LINE_LOW;
    issue_cmd(i2cbm_pkg::CMD_READ, 8'hFF, 1'b0);     // all zeros, NACK
    line_mode = LINE_RANDOM;
    issue_cmd(i2cbm_pkg::CMD_READ, 8'($urandom), 1'b1);
    issue_cmd(i2cbm_pkg::CMD_STOP, 8'h00, 1'b0);
    // reserved codes act as plain ticks
    issue_cmd(CMD_RSVD_FIRST, 8'hFF, 1'b1);
    issue_cmd(CMD_RSVD_FIRST + 3'd1, 8'h00, 1'b0);
    issue_cmd(CMD_RSVD_FIRST + 3'd2, 8'hFF, 1'b1);
  endtask

  // Widest ACK wait limit, with a slave that answers after a few polls
  task automatic test_timing_extremes();
    set_timing(10'd0, 10'd1023);
    ack_odds = 4;
    issue_cmd(i2cbm_pkg::CMD_WRITE, 8'h3C, 1'b0);
  endtask

  // Receiver holds off while ticks keep coming, then the sender pauses
  task automatic test_backpressure();
    set_timing(10'd1, 10'd8);
    src_gaps     = 1'b0;
    hold_request = 80;
    repeat (150) send_tick(random_tick());
    wait_results_drained();
    src_gaps = 1'b1;
    run_to_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_timing(10'd1, 10'd2);
        1: set_timing(10'd0, 10'd0);
        2: set_timing(10'd2, 10'd12);
        3: set_timing(10'd1, 10'd30);
        4: set_timing(10'd3, 10'd40);
        default: set_timing(10'($urandom_range(4)), 10'($urandom_range(40)));
      endcase
      // one phase runs without any idling on either side
      src_gaps  = (phase != 2);
      sink_gaps = (phase != 2);
      repeat (90) send_tick(random_tick());
      run_to_idle();
    end
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Receiver ready: random stalls, or a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : sink_ready
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_len     = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
      end else begin
        out_ready <= !sink_gaps || ($urandom_range(99) >= 26);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (tick_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %0d arrived with nothing pending", results_seen);
      end else begin
        want = tick_results.pop_front();
        if (out_item !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result %0d mismatch: exp scl=%b sda=%b busy=%b done=%b rd=%h ack=%b ",
                      "to=%b / got scl=%b sda=%b busy=%b done=%b rd=%h ack=%b to=%b"},
                     results_seen, want.scl_level, want.sda_release, want.busy_res,
                     want.done_res, want.read_byte, want.ack_received, want.timed_out,
                     out_item.scl_level, out_item.sda_release, out_item.busy_res,
                     out_item.done_res, out_item.read_byte, out_item.ack_received,
                     out_item.timed_out);
        end
      end
    end
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               tick_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    reset_bus_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed_zero_tpu();
    test_timing_extremes();
    test_backpressure();
    test_random_traffic();

    wait_results_drained();
    repeat (8) @(posedge clk_i);
    $display("covered %0d ticks: %0d start, %0d stop, %0d write (%0d acked, %0d timed out),",
             ticks_sent, n_starts, n_stops, n_writes, n_acked, n_timeouts);
    $display("  %0d read; %0d results checked, %0d mismatches", n_reads, results_seen,
             mismatches);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ i2c_bit_level_master.f @@
hw/rtl/i2cbm_pkg.sv
hw/rtl/i2cbm_front.sv
hw/rtl/i2cbm_queue.sv
hw/rtl/i2cbm_back.sv
hw/rtl/i2c_bit_level_master.sv
sim/i2c_bit_level_master_tb.sv
